// ----- design/jkv_pkg.sv -----
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared constants, types and helpers for the JSON key/value extractor.
// ----------------------------------------------------------------------------
package jkv_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int OFFSET_BITS   = 16;
	localparam int WIN_DEPTH     = MAX_KEY_BYTES + 1;
	localparam int KEY_REG_BYTES = 16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// 2^64 / 10, the largest accumulator that survives *10 without wrapping
	localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

	localparam logic [1:0] REG_KEY_LO  = 2'd0;
	localparam logic [1:0] REG_KEY_HI  = 2'd1;
	localparam logic [1:0] REG_KEY_LEN = 2'd2;
	localparam logic [1:0] REG_KIND    = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_KEY   = 3'd1;
	localparam logic [2:0] ST_NO_COLON = 3'd2;
	localparam logic [2:0] ST_NO_VALUE = 3'd3;
	localparam logic [2:0] ST_NO_DIGIT = 3'd4;
	localparam logic [2:0] ST_UNTERM   = 3'd5;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] int_value;
		logic [15:0] value_start;
		logic [15:0] value_length;
		logic        overflow;
	} result_t;

	function automatic logic [7:0] key_byte(input logic [127:0] key, input logic [3:0] idx);
		return key[idx*8 +: 8];
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

endpackage

// ----- design/jkv_cell.sv -----
// ----------------------------------------------------------------------------
// jkv_cell
// One byte of the key match window: holds a byte, passes it on, compares it.
// ----------------------------------------------------------------------------
module jkv_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  jkv_pkg::win_ctl_t ctl,
	input  logic [7:0]        byte_in,
	input  logic [7:0]        expected,
	input  logic              care,
	output logic [7:0]        byte_out,
	output logic              hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else if (ctl.clear) begin
			byte_q <= 8'd0;
		end else if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign hit      = !care || (byte_q == expected);

endmodule

// ----- design/jkv_parse.sv -----
// ----------------------------------------------------------------------------
// jkv_parse
// Document phase tracking, integer accumulation and string offset capture.
// ----------------------------------------------------------------------------
module jkv_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                last,
	input  logic [7:0]          data_byte,
	input  logic                value_kind,
	input  logic                key_hit,
	output jkv_pkg::result_t    result
);

	typedef enum logic [6:0] {
		PH_SEARCH   = 7'b0000001,
		PH_WS_KEY   = 7'b0000010,
		PH_WS_COLON = 7'b0000100,
		PH_SIGN     = 7'b0001000,
		PH_DIGITS   = 7'b0010000,
		PH_STRING   = 7'b0100000,
		PH_DONE     = 7'b1000000
	} phase_t;

	localparam int OB = jkv_pkg::OFFSET_BITS;

	phase_t          phase_q, phase_n;
	logic [OB-1:0]   pos_q, start_q, start_n, pos_inc, str_len;
	logic [63:0]     acc_q, acc_n;
	logic            neg_q, neg_n, wrap_q, wrap_n;
	logic [2:0]      held_q, held_n;

	logic            digit;
	logic [3:0]      dval;
	logic [63:0]     d64, d64_neg, mul_pos, mul_neg, acc_neg, start_w, len_w;
	logic            wrap_hit;
	logic [2:0]      st;

	assign digit   = (data_byte >= jkv_pkg::CH_ZERO) && (data_byte <= jkv_pkg::CH_NINE);
	assign dval    = 4'(data_byte - jkv_pkg::CH_ZERO);
	assign d64     = {60'd0, dval};
	assign d64_neg = 64'd0 - d64;
	// 10a + d and -(10a + d) as three-operand sums
	assign mul_pos = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + d64;
	assign mul_neg = ~{acc_q[60:0], 3'b000} + ~{acc_q[62:0], 1'b0} + (64'd2 - d64);
	assign acc_neg = 64'd0 - acc_q;
	assign wrap_hit = (acc_q > jkv_pkg::ACC_LIMIT) ||
	                  ((acc_q == jkv_pkg::ACC_LIMIT) && (dval > 4'd5));
	assign pos_inc = pos_q + OB'(1);
	assign str_len = pos_q - start_q;

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		neg_n   = neg_q;
		wrap_n  = wrap_q;
		start_n = start_q;
		held_n  = held_q;
		case (phase_q)
			PH_SEARCH: begin
				if (key_hit)
					phase_n = PH_WS_KEY;
			end
			PH_WS_KEY: begin
				if (!jkv_pkg::is_ws(data_byte)) begin
					if (data_byte == jkv_pkg::CH_COLON) begin
						phase_n = PH_WS_COLON;
					end else begin
						held_n  = jkv_pkg::ST_NO_COLON;
						phase_n = PH_DONE;
					end
				end
			end
			PH_WS_COLON: begin
				if (!jkv_pkg::is_ws(data_byte)) begin
					if (value_kind) begin
						if (data_byte == jkv_pkg::CH_QUOTE) begin
							start_n = pos_inc;
							phase_n = PH_STRING;
						end else begin
							held_n  = jkv_pkg::ST_NO_VALUE;
							phase_n = PH_DONE;
						end
					end else if (data_byte == jkv_pkg::CH_MINUS) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGN;
					end else if (digit) begin
						acc_n   = (last && neg_q) ? d64_neg : d64;
						phase_n = PH_DIGITS;
					end else begin
						held_n  = jkv_pkg::ST_NO_DIGIT;
						phase_n = PH_DONE;
					end
				end
			end
			PH_SIGN: begin
				if (digit) begin
					acc_n   = (last && neg_q && !value_kind) ? d64_neg : d64;
					phase_n = PH_DIGITS;
				end else begin
					held_n  = jkv_pkg::ST_NO_DIGIT;
					phase_n = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (digit) begin
					if (wrap_hit)
						wrap_n = 1'b1;
					acc_n = (last && neg_q && !value_kind) ? mul_neg : mul_pos;
				end else begin
					acc_n   = (neg_q && !value_kind) ? acc_neg : acc_q;
					held_n  = jkv_pkg::ST_OK;
					phase_n = PH_DONE;
				end
			end
			PH_STRING: begin
				if (data_byte == jkv_pkg::CH_QUOTE) begin
					acc_n   = 64'(str_len);
					held_n  = jkv_pkg::ST_OK;
					phase_n = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (phase_n)
			PH_SEARCH:   st = jkv_pkg::ST_NO_KEY;
			PH_WS_KEY:   st = jkv_pkg::ST_NO_COLON;
			PH_WS_COLON: st = jkv_pkg::ST_NO_VALUE;
			PH_SIGN:     st = jkv_pkg::ST_NO_DIGIT;
			PH_DIGITS:   st = jkv_pkg::ST_OK;
			PH_STRING:   st = jkv_pkg::ST_UNTERM;
			default:     st = held_n;
		endcase
	end

	assign start_w = 64'(start_n);
	assign len_w   = acc_n;

	always_comb begin
		result              = '0;
		result.status       = st;
		if (st == jkv_pkg::ST_OK) begin
			if (!value_kind) begin
				result.int_value = acc_n;
				result.overflow  = wrap_n;
			end else begin
				result.value_start  = start_w[15:0];
				result.value_length = len_w[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			pos_q   <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			start_q <= '0;
			held_q  <= jkv_pkg::ST_NO_KEY;
			wrap_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_SEARCH;
				pos_q   <= '0;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				start_q <= '0;
				held_q  <= jkv_pkg::ST_NO_KEY;
				wrap_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_inc;
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				start_q <= start_n;
				held_q  <= held_n;
				wrap_q  <= wrap_n;
			end
		end
	end

endmodule

// ----- design/json_key_value_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// json_key_value_extractor_unit
// Streams a flat JSON document and extracts the value of one configured key.
// ----------------------------------------------------------------------------
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+-------------------------------------
//  byte in  | byte_valid    | byte_stall    | data_byte, last
//  result   | result_valid  | result_stall  | status, int_value, value_start,
//           |               |               | value_length, overflow
//
//  One byte per clock unless byte_stall is high; the output register takes the
//  result with the last byte of a document. The window chain and the digit
//  accumulator both update in the cycle a byte is taken.
//  arst_n clears configuration, window, parser state and the output register.
//  A last byte waits only while an earlier result is held by result_stall.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         status,
	output logic signed [63:0] int_value,
	output logic [15:0]        value_start,
	output logic [15:0]        value_length,
	output logic               overflow,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int WD = jkv_pkg::WIN_DEPTH;

	logic [63:0]       key_lo_q, key_hi_q;
	logic [4:0]        key_len_q;
	logic              kind_q;
	logic [127:0]      key_all;

	logic              accept;
	jkv_pkg::win_ctl_t win_ctl;
	logic [7:0]        chain [WD+1];
	logic [WD-1:0]     hits;
	logic              len_ok, key_hit;

	jkv_pkg::result_t  res;
	logic              out_valid_q;
	jkv_pkg::result_t  out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= '0;
			kind_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				jkv_pkg::REG_KEY_LO:  key_lo_q  <= cfg_data;
				jkv_pkg::REG_KEY_HI:  key_hi_q  <= cfg_data;
				jkv_pkg::REG_KEY_LEN: key_len_q <= cfg_data[4:0];
				jkv_pkg::REG_KIND:    kind_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign key_all    = {key_hi_q, key_lo_q};
	assign byte_stall = out_valid_q && result_stall && last;
	assign accept     = byte_valid && !byte_stall;
	assign win_ctl.shift = accept && !last;
	assign win_ctl.clear = accept && last;

	assign chain[0] = data_byte;

	for (genvar k = 0; k < WD; k++) begin : g_win
		localparam logic [5:0] KI = 6'(k);
		logic [5:0] len6;
		logic [5:0] idx;
		logic [7:0] expected;
		logic       care;

		assign len6     = {1'b0, key_len_q};
		assign idx      = len6 - KI - 6'd1;
		assign care     = len6 >= KI;
		assign expected = (len6 > KI) ? jkv_pkg::key_byte(key_all, idx[3:0])
		                              : jkv_pkg::CH_QUOTE;

		jkv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (win_ctl),
			.byte_in  (chain[k]),
			.expected (expected),
			.care     (care),
			.byte_out (chain[k+1]),
			.hit      (hits[k])
		);
	end

	assign len_ok  = (key_len_q != 5'd0) && (32'(key_len_q) <= jkv_pkg::MAX_KEY_BYTES) &&
	                 (32'(key_len_q) <= jkv_pkg::KEY_REG_BYTES);
	assign key_hit = len_ok && (data_byte == jkv_pkg::CH_QUOTE) && (&hits);

	jkv_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.last       (last),
		.data_byte  (data_byte),
		.value_kind (kind_q),
		.key_hit    (key_hit),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (accept && last) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_q.status;
	assign int_value    = signed'(out_q.int_value);
	assign value_start  = out_q.value_start;
	assign value_length = out_q.value_length;
	assign overflow     = out_q.overflow;

endmodule

// ----- design/jkv_checker.sv -----
// ----------------------------------------------------------------------------
// jkv_checker
// Port-level checks for the JSON key/value extractor, bound to the top level.
// ----------------------------------------------------------------------------
module jkv_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic               last,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [2:0]         status,
	input  logic signed [63:0] int_value,
	input  logic [15:0]        value_start,
	input  logic [15:0]        value_length,
	input  logic               overflow
);

	logic last_taken;
	assign last_taken = byte_valid && !byte_stall && last;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) &&
		$stable(int_value) && $stable(value_length))
		else $error("stalled transaction changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= jkv_pkg::ST_UNTERM)
		else $error("status code out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != jkv_pkg::ST_OK |->
		int_value == 64'sd0 && value_start == 16'd0 && value_length == 16'd0 && !overflow)
		else $error("payload not cleared on error status");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(last_taken))
		else $error("result without a last byte");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		last_taken |=> result_valid)
		else $error("last byte gave no result");

endmodule

bind json_key_value_extractor_unit jkv_checker u_jkv_checker (.*);

// ----- tb/json_key_value_extractor_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_key_value_extractor_unit_checker
// Watches the byte, result and register ports of the extractor. It keeps its
// own copy of the scan state and the registers, predicts the result of every
// document from the bytes taken, and compares each result transaction with
// the oldest prediction.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit_checker
	import jkv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic               last,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [2:0]         status,
	input  logic signed [63:0] int_value,
	input  logic [15:0]        value_start,
	input  logic [15:0]        value_length,
	input  logic               overflow,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output int                 failures,
	output int                 pending,
	output int                 results_seen
);

	localparam logic [63:0] TENTH_OF_MAX = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;

	typedef enum logic [2:0] {
		SCAN_KEY,
		AFTER_KEY,
		AFTER_COLON,
		AFTER_MINUS,
		IN_DIGITS,
		IN_STRING,
		SETTLED
	} scan_phase_t;

	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [4:0]  key_len;
	logic        kind;

	scan_phase_t phase;
	logic [7:0]  recent [WIN_DEPTH];
	logic [15:0] pos;
	logic [15:0] str_start;
	logic [63:0] acc;
	logic        minus;
	logic        wrapped;
	logic [2:0]  held;
	result_t     expected_q [$];

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic [7:0] key_char(input int k);
		return (k < 8) ? key_lo[8*k +: 8] : key_hi[8*(k-8) +: 8];
	endfunction

	// recent[0] is the byte before b
	function automatic logic key_hit(input logic [7:0] b);
		int n;
		n = key_len;
		if (n == 0 || n > MAX_KEY_BYTES || b != CH_QUOTE)
			return 1'b0;
		if (recent[n] != CH_QUOTE)
			return 1'b0;
		for (int k = 0; k < n; k++)
			if (recent[k] != key_char(n - 1 - k))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic restart();
		phase = SCAN_KEY;
		for (int k = 0; k < WIN_DEPTH; k++)
			recent[k] = '0;
		pos = '0;
		str_start = '0;
		acc = '0;
		minus = 1'b0;
		wrapped = 1'b0;
		held = ST_NO_KEY;
	endtask

	task automatic take_digit(input logic [3:0] d);
		if (acc > TENTH_OF_MAX || (acc == TENTH_OF_MAX && d > 4'd5))
			wrapped = 1'b1;
		acc = acc * 64'd10 + 64'(d);
	endtask

	task automatic settle(input logic [2:0] st);
		held = st;
		if (st == ST_OK && !kind && minus)
			acc = -acc;
		phase = SETTLED;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic       is_digit;
		logic [2:0] st;
		result_t    r;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		case (phase)
		SCAN_KEY: begin
			if (key_hit(b))
				phase = AFTER_KEY;
		end
		AFTER_KEY: begin
			if (!is_blank(b)) begin
				if (b == CH_COLON)
					phase = AFTER_COLON;
				else
					settle(ST_NO_COLON);
			end
		end
		AFTER_COLON: begin
			if (!is_blank(b)) begin
				if (kind) begin
					if (b == CH_QUOTE) begin
						str_start = pos + 16'd1;
						phase = IN_STRING;
					end else
						settle(ST_NO_VALUE);
				end else if (b == CH_MINUS) begin
					minus = 1'b1;
					phase = AFTER_MINUS;
				end else if (is_digit) begin
					acc = '0;
					take_digit(4'(b - CH_ZERO));
					phase = IN_DIGITS;
				end else
					settle(ST_NO_DIGIT);
			end
		end
		AFTER_MINUS: begin
			if (is_digit) begin
				acc = '0;
				take_digit(4'(b - CH_ZERO));
				phase = IN_DIGITS;
			end else
				settle(ST_NO_DIGIT);
		end
		IN_DIGITS: begin
			if (is_digit)
				take_digit(4'(b - CH_ZERO));
			else
				settle(ST_OK);
		end
		IN_STRING: begin
			if (b == CH_QUOTE) begin
				acc = {48'd0, pos - str_start};
				settle(ST_OK);
			end
		end
		default: ;
		endcase

		for (int k = WIN_DEPTH - 1; k > 0; k--)
			recent[k] = recent[k-1];
		recent[0] = b;
		pos = pos + 16'd1;

		if (fin) begin
			case (phase)
			SCAN_KEY:    st = ST_NO_KEY;
			AFTER_KEY:   st = ST_NO_COLON;
			AFTER_COLON: st = ST_NO_VALUE;
			AFTER_MINUS: st = ST_NO_DIGIT;
			IN_DIGITS: begin
				settle(ST_OK);
				st = ST_OK;
			end
			IN_STRING:   st = ST_UNTERM;
			default:     st = held;
			endcase
			r = '0;
			r.status = st;
			if (st == ST_OK) begin
				if (!kind) begin
					r.int_value = acc;
					r.overflow = wrapped;
				end else begin
					r.value_start = str_start;
					r.value_length = acc[15:0];
				end
			end
			expected_q.push_back(r);
			restart();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			key_lo = '0;
			key_hi = '0;
			key_len = '0;
			kind = 1'b0;
			restart();
			expected_q.delete();
			failures = 0;
			results_seen = 0;
		end else begin
			if (byte_valid && !byte_stall)
				scan_byte(data_byte, last);
			if (result_valid && !result_stall) begin
				got.status = status;
				got.int_value = int_value;
				got.value_start = value_start;
				got.value_length = value_length;
				got.overflow = overflow;
				results_seen++;
				if (expected_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result transaction with none pending, status %0d",
							$time, status);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display({"%0t: mismatch (exp/got) status %0d/%0d int %0d/%0d ",
								"start %0d/%0d len %0d/%0d ovf %0d/%0d"}, $time,
								want.status, got.status,
								$signed(want.int_value), $signed(got.int_value),
								want.value_start, got.value_start,
								want.value_length, got.value_length,
								want.overflow, got.overflow);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_KEY_LO:  key_lo = cfg_data;
				REG_KEY_HI:  key_hi = cfg_data;
				REG_KEY_LEN: key_len = cfg_data[4:0];
				REG_KIND:    kind = cfg_data[0];
				default: ;
				endcase
			end
		end
		pending = expected_q.size();
	end

endmodule

// ----- tb/json_key_value_extractor_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_key_value_extractor_unit_test
// Feeds JSON documents byte by byte into the extractor: directed documents for
// every status, integer extremes and key lengths, then random documents under
// random register settings, with random gaps and result stalls. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit_test;
	import jkv_pkg::*;

	localparam logic [7:0] CH_LOW_A = "a";
	localparam logic [7:0] CH_LOW_Z = "z";

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	logic [7:0]         data_byte = '0;
	logic               last = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [2:0]         status;
	logic signed [63:0] int_value;
	logic [15:0]        value_start;
	logic [15:0]        value_length;
	logic               overflow;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;
	int                 failures;
	int                 pending;
	int                 results_seen;

	logic [7:0] doc [$];
	logic [7:0] cur_key [16];
	logic [4:0] bad_len [3] = '{5'd17, 5'd31, 5'd0};
	logic       kind_cfg = 1'b0;
	logic       steady = 1'b0;
	logic       quiet = 1'b0;
	int         stall_left = 0;
	int         free_left = 0;
	int         bytes_sent = 0;
	int         docs_sent = 0;

	json_key_value_extractor_unit dut (.*);

	json_key_value_extractor_unit_checker result_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(negedge clk) begin
		if (quiet)
			result_stall <= 1'b0;
		else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (free_left > 0)
				free_left--;
			else begin
				free_left = $urandom_range(0, 8);
				stall_left = pick_gap();
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int idle;
		idle = steady ? 0 : pick_gap();
		@(negedge clk);
		if (idle > 0) begin
			byte_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last <= fin;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc.size(); i++)
			send_byte(doc[i], i == doc.size() - 1);
		docs_sent++;
		doc.delete();
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			doc.push_back(s[i]);
	endtask

	task automatic text_doc(input string s);
		put_text(s);
		send_doc();
	endtask

	task automatic put_key(input int n);
		doc.push_back(CH_QUOTE);
		for (int i = 0; i < n; i++)
			doc.push_back(cur_key[i]);
		doc.push_back(CH_QUOTE);
	endtask

	task automatic put_ws();
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 3))
			0: doc.push_back(CH_SPACE);
			1: doc.push_back(CH_TAB);
			2: doc.push_back(CH_CR);
			default: doc.push_back(CH_LF);
			endcase
		end
	endtask

	task automatic put_number();
		int ndig;
		int r;
		r = $urandom_range(0, 9);
		if ($urandom_range(0, 2) == 0)
			doc.push_back(CH_MINUS);
		if (r < 6)
			ndig = $urandom_range(1, 6);
		else if (r < 8)
			ndig = $urandom_range(18, 20);
		else
			ndig = $urandom_range(21, 25);
		repeat (ndig)
			doc.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
	endtask

	task automatic put_string();
		logic [7:0] ch;
		doc.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 10)) begin
			ch = 8'($urandom_range(0, 255));
			while (ch == CH_QUOTE)
				ch = 8'($urandom_range(0, 255));
			doc.push_back(ch);
		end
		doc.push_back(CH_QUOTE);
	endtask

	// well-formed document, then sometimes truncated, corrupted or replaced by noise
	task automatic build_doc(input int key_n);
		int n;
		put_text("{");
		repeat ($urandom_range(0, 2)) begin
			doc.push_back(CH_QUOTE);
			repeat ($urandom_range(1, 3))
				doc.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
			put_text("\":");
			repeat ($urandom_range(1, 3))
				doc.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
			put_text(",");
		end
		put_key(key_n);
		put_ws();
		doc.push_back(CH_COLON);
		put_ws();
		if (($urandom_range(0, 9) < 8) == kind_cfg)
			put_string();
		else
			put_number();
		if ($urandom_range(0, 1)) begin
			put_ws();
			put_text("}");
		end
		case ($urandom_range(0, 9))
		0, 1: begin
			n = $urandom_range(1, doc.size());
			while (doc.size() > n)
				void'(doc.pop_back());
		end
		2: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
		3: begin
			doc.delete();
			repeat ($urandom_range(1, 12))
				doc.push_back(8'($urandom_range(0, 255)));
		end
		default: ;
		endcase
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
	endtask

	task automatic program_regs(input logic [4:0] len, input logic kind);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] junk;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = cur_key[i];
			hi[8*i +: 8] = cur_key[8+i];
		end
		junk = {$urandom, $urandom};
		write_reg(REG_KEY_LO, lo);
		write_reg(REG_KEY_HI, hi);
		write_reg(REG_KEY_LEN, {junk[63:5], len});
		write_reg(REG_KIND, {junk[63:1], kind});
		@(negedge clk);
		cfg_we <= 1'b0;
		kind_cfg = kind;
	endtask

	task automatic settle_down();
		@(negedge clk);
		byte_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int klen;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers at reset: empty key
		text_doc("{\"a\":1}");

		for (int i = 0; i < 16; i++)
			cur_key[i] = 8'($urandom_range(0, 255));
		cur_key[0] = "i";
		cur_key[1] = "d";
		settle_down();
		program_regs(5'd2, 1'b0);
		text_doc("{\"id\":42}");
		text_doc("{\"id\" :\t-7,\"x\":1}");
		text_doc("{\"id\":18446744073709551615}");
		text_doc("{\"id\":18446744073709551616}");
		text_doc("{\"id\":-9223372036854775808}");
		text_doc("{\"id\":-99999999999999999999999}");
		text_doc("{\"id\":-0}");
		text_doc("\"id\"");
		text_doc("{\"id\"\n\015\t ");
		text_doc("{\"id\"x:1}");
		text_doc("{\"id\":");
		text_doc("{\"id\": \015\n");
		text_doc("{\"id\":-");
		text_doc("{\"id\":-x}");
		text_doc("{\"id\":\"s\"}");
		text_doc("{\"id\":123");
		text_doc("{\"id\":1} \"id\":2");
		text_doc("\"");

		for (int i = 0; i < 16; i++)
			cur_key[i] = CH_LOW_A + 8'(i);
		settle_down();
		program_regs(5'd16, 1'b1);
		put_text("{");
		put_key(16);
		put_text(": \"hello\"}");
		send_doc();
		put_key(16);
		put_text(":\"\"");
		send_doc();
		put_text("{");
		put_key(16);
		put_text(":\"ab");
		send_doc();
		put_key(16);
		put_text(":12}");
		send_doc();
		put_key(16);
		put_text(":\t");
		send_doc();

		// key lengths that can never match
		for (int j = 0; j < 3; j++) begin
			settle_down();
			program_regs(bad_len[j], 1'b0);
			put_key(16);
			put_text(":5");
			send_doc();
		end

		for (int i = 0; i < 16; i++)
			cur_key[i] = 8'hFF;
		settle_down();
		program_regs(5'd8, 1'b0);
		put_key(8);
		put_text(":-12}");
		send_doc();

		do begin
			case ($urandom_range(0, 7))
			0: klen = 0;
			1: klen = $urandom_range(17, 31);
			2: klen = 16;
			3: klen = 1;
			default: klen = $urandom_range(2, 15);
			endcase
			for (int i = 0; i < 16; i++)
				cur_key[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(CH_LOW_A, CH_LOW_Z));
			settle_down();
			program_regs(5'(klen), 1'($urandom_range(0, 1)));
			steady = ($urandom_range(0, 4) == 0);
			quiet = steady;
			repeat ($urandom_range(1, 3)) begin
				build_doc((klen >= 1 && klen <= 16) ? klen : $urandom_range(1, 16));
				send_doc();
			end
			steady = 1'b0;
			quiet = 1'b0;
		end while (bytes_sent < 450);

		settle_down();
		repeat (10) @(posedge clk);
		$display("covered %0d documents, %0d bytes, %0d results checked",
			docs_sent, bytes_sent, results_seen);
		$display("all status codes, integer limits, key lengths 0 to 31");
		if (failures == 0 && pending == 0)
			$display("json_key_value_extractor_unit regression: pass");
		else begin
			$display("%0d failures, %0d results never arrived", failures, pending);
			$display("json_key_value_extractor_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("json_key_value_extractor_unit regression: fail");
		$finish;
	end

endmodule
